@@ rtl/core/atr_pkg.sv @@
package atr_pkg;

  localparam int unsigned PRICE_BITS   = 32;
  localparam int unsigned WINDOW_MAX   = 64;
  localparam int unsigned LEN_BITS     = 7;
  localparam int unsigned SLOT_BITS    = 6;
  localparam int unsigned SUM_BITS     = 38;
  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned DIV_BITS     = SUM_BITS + FRAC_BITS;
  localparam int unsigned DIV_CNT_BITS = 6;
  localparam int unsigned AVG_BITS     = 40;
  localparam int unsigned PROD_BITS    = AVG_BITS + 7;

  localparam logic [LEN_BITS-1:0]     LEN_RESET = LEN_BITS'(14);
  localparam logic [LEN_BITS-1:0]     LEN_MAX   = LEN_BITS'(WINDOW_MAX);
  localparam logic [LEN_BITS-1:0]     LEN_MIN   = LEN_BITS'(1);
  localparam logic [DIV_CNT_BITS-1:0] CNT_LAST  = DIV_CNT_BITS'(DIV_BITS - 1);
  localparam logic [PROD_BITS-1:0]    PCT_SCALE = PROD_BITS'(100);

  typedef enum logic [1:0] {
    CLASS_LOW    = 2'd0,
    CLASS_MEDIUM = 2'd1,
    CLASS_HIGH   = 2'd2
  } vol_class_e;

endpackage

@@ rtl/core/atr_ram.sv @@
module atr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/atr_div.sv @@
module atr_div
  import atr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DIV_BITS-1:0] dividend_i,
  input  logic [LEN_BITS-1:0] divisor_i,
  output logic                done_o,
  output logic [DIV_BITS-1:0] quotient_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [LEN_BITS-1:0]     rem_q, rem_d;
  logic [LEN_BITS-1:0]     div_q, div_d;
  logic [DIV_BITS-1:0]     quo_q, quo_d;
  logic [LEN_BITS:0]       shifted;
  logic [LEN_BITS:0]       diff;
  logic                    ge;

  assign shifted = {rem_q, quo_q[DIV_BITS-1]};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
      quo_d = {quo_q[DIV_BITS-2:0], ge};
      cnt_d = cnt_q + DIV_CNT_BITS'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/core/average_true_range_classifier.sv @@
// Each item runs ST_RANGE, ST_ACCUM, ST_DIV, ST_CLASS, ST_DONE; in ST_DIV the
// bit-serial divider yields 46 quotient bits, one a cycle, then its done.
// Only ST_IDLE takes items; before the window fills, ST_DIV and ST_CLASS are skipped.
// A finished result waits in the output register while the next item runs.
// Reset (rst_ni low, asynchronous): window length 14, sum, prior close,
// bar count and ring slot cleared; a length write sets length 1..64 and clears the rest.
module average_true_range_classifier
  import atr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LEN_BITS-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // high_price [31:0], low_price [63:32], close_price [95:64]
  input  logic [95:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // range_average [39:0], volatility_class [41:40], zero [47:42]
  output logic [47:0]         m_axis_tdata,
  // average_valid [0]
  output logic                m_axis_tuser
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RANGE = 6'b000010,
    ST_ACCUM = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_CLASS = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [LEN_BITS-1:0]   len_q, len_d;
  logic [SUM_BITS-1:0]   sum_q, sum_d;
  logic [PRICE_BITS-1:0] prior_q, prior_d;
  logic [LEN_BITS-1:0]   bars_q, bars_d;
  logic [SLOT_BITS-1:0]  slot_q, slot_d;

  logic [PRICE_BITS-1:0] hi_q, hi_d;
  logic [PRICE_BITS-1:0] lo_q, lo_d;
  logic [PRICE_BITS-1:0] cl_q, cl_d;
  logic [PRICE_BITS-1:0] tr_q, tr_d;
  logic [AVG_BITS-1:0]   avg_q, avg_d;
  logic                  valid_q, valid_d;
  vol_class_e            cls_q, cls_d;

  logic                  m_tvalid_q, m_tvalid_d;
  logic [AVG_BITS-1:0]   m_avg_q, m_avg_d;
  logic                  m_valid_q, m_valid_d;
  vol_class_e            m_cls_q, m_cls_d;

  logic [PRICE_BITS-1:0] d_hl, d_hp, d_lp;
  logic [PRICE_BITS-1:0] ring_rdata;
  logic                  ring_we;
  logic                  div_start;
  logic                  div_done;
  logic [DIV_BITS-1:0]   div_quot;
  logic [SUM_BITS-1:0]   sum_next;
  logic [LEN_BITS-1:0]   bars_next;
  logic [LEN_BITS-1:0]   slot_inc;
  logic [LEN_BITS-1:0]   cfg_len;
  logic [PROD_BITS-1:0]  avg_pct;
  logic [PROD_BITS-1:0]  low_ref;
  logic [PROD_BITS-1:0]  high_ref;

  atr_ram #(
    .WIDTH(PRICE_BITS),
    .DEPTH(WINDOW_MAX)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(slot_q),
    .wdata_i(tr_q),
    .raddr_i(slot_q),
    .rdata_o(ring_rdata)
  );

  atr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({sum_next, FRAC_BITS'(0)}),
    .divisor_i (len_q),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  assign d_hl = (hi_q >= lo_q) ? hi_q - lo_q : lo_q - hi_q;
  assign d_hp = (hi_q >= prior_q) ? hi_q - prior_q : prior_q - hi_q;
  assign d_lp = (lo_q >= prior_q) ? lo_q - prior_q : prior_q - lo_q;

  assign sum_next  = sum_q - ((bars_q >= len_q) ? SUM_BITS'(ring_rdata) : '0)
                     + SUM_BITS'(tr_q);
  assign bars_next = (bars_q >= len_q) ? len_q : bars_q + LEN_BITS'(1);
  assign slot_inc  = {1'b0, slot_q} + LEN_BITS'(1);

  assign cfg_len = (cfg_wdata_i == '0) ? LEN_MIN :
                   (cfg_wdata_i > LEN_MAX) ? LEN_MAX : cfg_wdata_i;

  assign avg_pct  = PROD_BITS'(avg_q) * PCT_SCALE;
  assign low_ref  = PROD_BITS'({cl_q, FRAC_BITS'(0)});
  assign high_ref = PROD_BITS'({cl_q, 9'd0}) + low_ref;

  assign ring_we   = (state_q == ST_ACCUM);
  assign div_start = (state_q == ST_ACCUM) && (bars_next >= len_q);

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    sum_d      = sum_q;
    prior_d    = prior_q;
    bars_d     = bars_q;
    slot_d     = slot_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    cl_d       = cl_q;
    tr_d       = tr_q;
    avg_d      = avg_q;
    valid_d    = valid_q;
    cls_d      = cls_q;
    m_tvalid_d = m_tvalid_q && !m_axis_tready;
    m_avg_d    = m_avg_q;
    m_valid_d  = m_valid_q;
    m_cls_d    = m_cls_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          hi_d    = s_axis_tdata[31:0];
          lo_d    = s_axis_tdata[63:32];
          cl_d    = s_axis_tdata[95:64];
          state_d = ST_RANGE;
        end
      end
      ST_RANGE: begin
        tr_d = d_hl;
        if (bars_q != '0) begin
          if (d_hp > tr_d) tr_d = d_hp;
          if (d_lp > tr_d) tr_d = d_lp;
        end
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        sum_d   = sum_next;
        bars_d  = bars_next;
        slot_d  = (slot_inc >= len_q) ? '0 : slot_inc[SLOT_BITS-1:0];
        prior_d = cl_q;
        if (bars_next >= len_q) begin
          state_d = ST_DIV;
        end else begin
          avg_d   = '0;
          valid_d = 1'b0;
          cls_d   = CLASS_LOW;
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          avg_d   = div_quot[AVG_BITS-1:0];
          state_d = ST_CLASS;
        end
      end
      ST_CLASS: begin
        valid_d = 1'b1;
        if (cl_q == '0) begin
          cls_d = CLASS_MEDIUM;
        end else if (avg_pct < low_ref) begin
          cls_d = CLASS_LOW;
        end else if (avg_pct > high_ref) begin
          cls_d = CLASS_HIGH;
        end else begin
          cls_d = CLASS_MEDIUM;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_avg_d    = avg_q;
          m_valid_d  = valid_q;
          m_cls_d    = cls_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      len_d   = cfg_len;
      sum_d   = '0;
      prior_d = '0;
      bars_d  = '0;
      slot_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      len_q      <= LEN_RESET;
      sum_q      <= '0;
      prior_q    <= '0;
      bars_q     <= '0;
      slot_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      sum_q      <= sum_d;
      prior_q    <= prior_d;
      bars_q     <= bars_d;
      slot_q     <= slot_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q      <= hi_d;
    lo_q      <= lo_d;
    cl_q      <= cl_d;
    tr_q      <= tr_d;
    avg_q     <= avg_d;
    valid_q   <= valid_d;
    cls_q     <= cls_d;
    m_avg_q   <= m_avg_d;
    m_valid_q <= m_valid_d;
    m_cls_q   <= m_cls_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {6'd0, m_cls_q, m_avg_q};
  assign m_axis_tuser  = m_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bars_q <= len_q)
    else $error("bar count beyond window length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, slot_q} < len_q)
    else $error("ring slot outside window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bars_q == '0) |-> (sum_q == '0))
    else $error("window sum without bars");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[41:0] == '0))
    else $error("result before window full not cleared");

endmodule
